@@ hdl/hps_pkg.sv @@
// Shared types, constants and tables for the head pose smoother.
// Depends on nothing; every other file imports it.
package hps_pkg;

   localparam int SMOOTH_W    = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int MUL_W       = 35;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int CORD_W      = 36;
   localparam int CORD_STEPS  = 30;
   localparam int ROOT_STEPS  = 32;
   localparam int DIV_STEPS   = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_POS_SMOOTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SMOOTH = 8'd1;

   localparam logic [SMOOTH_W-1:0]   SMOOTH_MAX      = 16'd64880;
   localparam logic [SMOOTH_W:0]     ONE_Q16         = 17'd65536;
   localparam logic signed [35:0]    LERP_LIMIT      = 36'sd1073204953;
   localparam logic signed [CORD_W-1:0] CORDIC_GAIN_INV = 36'sd652032874;
   localparam logic signed [31:0]    WEIGHT_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]    INT32_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]    INT32_MIN       = 32'sh8000_0000;
   localparam logic signed [34:0]    COMP_MAX        = 35'sd8589934591;
   localparam logic [63:0]           Q60_ONE         = 64'h1000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] in_pos_x;
      logic signed [31:0] in_pos_y;
      logic signed [31:0] in_pos_z;
      logic signed [31:0] in_quat_w;
      logic signed [31:0] in_quat_x;
      logic signed [31:0] in_quat_y;
      logic signed [31:0] in_quat_z;
      logic               in_valid;
      logic [63:0]        in_stamp;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_quat_w;
      logic signed [31:0] out_quat_x;
      logic signed [31:0] out_quat_y;
      logic signed [31:0] out_quat_z;
      logic               out_valid;
      logic [63:0]        out_stamp;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_POS_MUL,
      ST_POS_ACC,
      ST_QSEL,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_DOT_FIX,
      ST_LERP_MUL,
      ST_LERP_ACC,
      ST_DSQ_MUL,
      ST_ROOT0_GO,
      ST_ROOT0_WAIT,
      ST_VEC_GO,
      ST_VEC_WAIT,
      ST_TH_MUL,
      ST_TH_ACC,
      ST_ROT_GO,
      ST_ROT_WAIT,
      ST_WDIV_GO,
      ST_WDIV_WAIT,
      ST_COMB_MUL,
      ST_COMB_ACC,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_ROOT1_GO,
      ST_ROOT1_WAIT,
      ST_NDIV_GO,
      ST_NDIV_WAIT,
      ST_DONE
   } state_type;

   // atan(2^-i) in Q.30
   function automatic logic signed [CORD_W-1:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0:    return 36'sd843314857;
         5'd1:    return 36'sd497837829;
         5'd2:    return 36'sd263043837;
         5'd3:    return 36'sd133525159;
         5'd4:    return 36'sd67021687;
         5'd5:    return 36'sd33543516;
         5'd6:    return 36'sd16775851;
         5'd7:    return 36'sd8388437;
         5'd8:    return 36'sd4194283;
         5'd9:    return 36'sd2097149;
         5'd10:   return 36'sd1048576;
         5'd11:   return 36'sd524288;
         5'd12:   return 36'sd262144;
         5'd13:   return 36'sd131072;
         5'd14:   return 36'sd65536;
         5'd15:   return 36'sd32768;
         5'd16:   return 36'sd16384;
         5'd17:   return 36'sd8192;
         5'd18:   return 36'sd4096;
         5'd19:   return 36'sd2048;
         5'd20:   return 36'sd1024;
         5'd21:   return 36'sd512;
         5'd22:   return 36'sd256;
         5'd23:   return 36'sd128;
         5'd24:   return 36'sd64;
         5'd25:   return 36'sd32;
         5'd26:   return 36'sd16;
         5'd27:   return 36'sd8;
         5'd28:   return 36'sd4;
         5'd29:   return 36'sd2;
         default: return 36'sd0;
      endcase
   endfunction

endpackage

@@ hdl/head_pose_smoother_unit.sv @@
// Head pose smoother top level over a shared multiplier, CORDIC, root and divider.
// Depends on hps_pkg, hps_mul, hps_cordic, hps_root, hps_div.
// Rotation smoothing takes the lerp path for nearly aligned quaternions, else the slerp path;
// a zero blended length skips the normalising divides and returns a zero quaternion.
// One sample at a time: req_ready is high only in idle, which follows once the output is free.
// Reset (synchronous, active high) clears both factors and marks the held pose invalid.
module head_pose_smoother_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  hps_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output hps_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hps_pkg::SMOOTH_W-1:0]       csr_data
);
   import hps_pkg::*;

   state_type state_ff, state_in;

   logic [SMOOTH_W-1:0] s_pos_ff, s_rot_ff, csr_val;
   logic [SMOOTH_W:0]   tp, tr;

   req_type             smp_ff;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;
   logic                held_valid_ff;
   logic signed [31:0]  held_pos_ff [3];
   logic signed [31:0]  held_q_ff   [4];
   logic signed [31:0]  pos_res_ff  [3];
   logic signed [31:0]  qout_ff     [4];
   logic signed [32:0]  bq_ff       [4];
   logic signed [34:0]  c_ff        [4];
   logic signed [35:0]  sin_ff      [2];
   logic signed [31:0]  w_ff        [2];
   logic signed [35:0]  dot_ff, theta_ff, ub_ff, ua_ff;
   logic signed [64:0]  comb_ff;
   logic [31:0]         s0_ff, len_ff;
   logic [63:0]         sum_ff;
   logic [2:0]          idx_ff;

   logic signed [31:0]  smp_pos [3];
   logic signed [31:0]  smp_q   [4];
   logic [33:0]         mag     [4];
   logic [1:0]          i2;
   logic                pos_on, rot_on, out_free;

   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod_ff, prod_r16, prod_f30;
   logic signed [35:0]       dabs;
   logic signed [65:0]       lerp_sum, comb_sum;
   logic signed [35:0]       sabs;

   logic                     root_start, root_done;
   logic [63:0]              root_n, root_res;
   logic                     cord_start, cord_vec, cord_done;
   logic signed [CORD_W-1:0] cord_x0, cord_y0, cord_z0, cord_x, cord_y, cord_z;
   logic                     div_start, div_done, div_sat;
   logic [63:0]              div_num;
   logic [31:0]              div_den;
   logic [30:0]              div_quot;
   logic signed [31:0]       wq, nq;

   function automatic logic signed [34:0] clamp_c(input logic signed [65:0] v);
      if (v > 66'sd8589934591)
         return COMP_MAX;
      else if (v < -66'sd8589934591)
         return -COMP_MAX;
      return v[34:0];
   endfunction

   hps_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   hps_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cord_start),
      .vectoring (cord_vec),
      .x0        (cord_x0),
      .y0        (cord_y0),
      .z0        (cord_z0),
      .x_ff      (cord_x),
      .y_ff      (cord_y),
      .z_ff      (cord_z),
      .done_ff   (cord_done)
   );

   hps_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_n),
      .res_ff   (root_res),
      .done_ff  (root_done)
   );

   hps_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (div_den),
      .quot_ff (div_quot),
      .sat_ff  (div_sat),
      .done_ff (div_done)
   );

   assign smp_pos[0] = smp_ff.in_pos_x;
   assign smp_pos[1] = smp_ff.in_pos_y;
   assign smp_pos[2] = smp_ff.in_pos_z;
   assign smp_q[0]   = smp_ff.in_quat_w;
   assign smp_q[1]   = smp_ff.in_quat_x;
   assign smp_q[2]   = smp_ff.in_quat_y;
   assign smp_q[3]   = smp_ff.in_quat_z;

   for (genvar g = 0; g < 4; g++) begin : g_mag
      logic signed [34:0] cabs;
      assign cabs   = (c_ff[g] < 0) ? -c_ff[g] : c_ff[g];
      assign mag[g] = cabs[33:0];
   end

   assign tp       = ONE_Q16 - {1'b0, s_pos_ff};
   assign tr       = ONE_Q16 - {1'b0, s_rot_ff};
   assign i2       = idx_ff[1:0];
   assign pos_on   = (s_pos_ff != '0) && held_valid_ff;
   assign rot_on   = (s_rot_ff != '0) && held_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign csr_val  = (csr_data > SMOOTH_MAX) ? SMOOTH_MAX : csr_data;

   assign prod_r16 = (prod_ff + 70'sd32768) >>> 16;
   assign prod_f30 = prod_ff >>> 30;
   assign dabs     = (dot_ff < 0) ? -dot_ff : dot_ff;
   assign lerp_sum = 66'(held_q_ff[i2]) + prod_r16[65:0];
   assign comb_sum = (66'(comb_ff) + 66'(signed'(prod_ff[64:0]))) >>> 30;
   assign sabs     = (sin_ff[idx_ff[0]] < 0) ? -sin_ff[idx_ff[0]] : sin_ff[idx_ff[0]];

   assign wq = div_sat ? WEIGHT_MAX : signed'({1'b0, div_quot});
   assign nq = div_sat ? ((c_ff[i2] < 0) ? INT32_MIN : INT32_MAX)
                       : ((c_ff[i2] < 0) ? -signed'({1'b0, div_quot})
                                         : signed'({1'b0, div_quot}));

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = pos_on ? ST_POS_MUL : ST_QSEL;
         ST_POS_MUL:    state_in = ST_POS_ACC;
         ST_POS_ACC:    state_in = (idx_ff == 3'd2) ? ST_QSEL : ST_POS_MUL;
         ST_QSEL:       state_in = rot_on ? ST_DOT_MUL : ST_DONE;
         ST_DOT_MUL:    state_in = ST_DOT_ACC;
         ST_DOT_ACC:    state_in = (idx_ff == 3'd3) ? ST_DOT_FIX : ST_DOT_MUL;
         ST_DOT_FIX:    state_in = (dabs > LERP_LIMIT) ? ST_LERP_MUL : ST_DSQ_MUL;
         ST_LERP_MUL:   state_in = ST_LERP_ACC;
         ST_LERP_ACC:   state_in = (idx_ff == 3'd3) ? ST_SQ_MUL : ST_LERP_MUL;
         ST_DSQ_MUL:    state_in = ST_ROOT0_GO;
         ST_ROOT0_GO:   state_in = ST_ROOT0_WAIT;
         ST_ROOT0_WAIT: if (root_done) state_in = ST_VEC_GO;
         ST_VEC_GO:     state_in = ST_VEC_WAIT;
         ST_VEC_WAIT:   if (cord_done) state_in = ST_TH_MUL;
         ST_TH_MUL:     state_in = ST_TH_ACC;
         ST_TH_ACC:     state_in = ST_ROT_GO;
         ST_ROT_GO:     state_in = ST_ROT_WAIT;
         ST_ROT_WAIT:   if (cord_done) state_in = idx_ff[0] ? ST_WDIV_GO : ST_ROT_GO;
         ST_WDIV_GO:    state_in = ST_WDIV_WAIT;
         ST_WDIV_WAIT:  if (div_done) state_in = idx_ff[0] ? ST_COMB_MUL : ST_WDIV_GO;
         ST_COMB_MUL:   state_in = ST_COMB_ACC;
         ST_COMB_ACC:   state_in = (idx_ff == 3'd7) ? ST_SQ_MUL : ST_COMB_MUL;
         ST_SQ_MUL:     state_in = ST_SQ_ACC;
         ST_SQ_ACC:     state_in = (idx_ff == 3'd3) ? ST_ROOT1_GO : ST_SQ_MUL;
         ST_ROOT1_GO:   state_in = ST_ROOT1_WAIT;
         ST_ROOT1_WAIT: if (root_done) state_in = (root_res == '0) ? ST_DONE : ST_NDIV_GO;
         ST_NDIV_GO:    state_in = ST_NDIV_WAIT;
         ST_NDIV_WAIT:  if (div_done) state_in = (idx_ff == 3'd3) ? ST_DONE : ST_NDIV_GO;
         ST_DONE:       if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // unit controls and operand selection
   always_comb begin
      op_a       = '0;
      op_b       = '0;
      root_start = 1'b0;
      root_n     = sum_ff;
      cord_start = 1'b0;
      cord_vec   = 1'b0;
      cord_x0    = CORDIC_GAIN_INV;
      cord_y0    = '0;
      cord_z0    = idx_ff[0] ? ub_ff : ua_ff;
      div_start  = 1'b0;
      div_num    = {mag[i2], 28'b0} + 64'(len_ff >> 1);
      div_den    = len_ff;
      case (state_ff)
         ST_POS_MUL: begin
            op_a = MUL_W'(33'(smp_pos[i2]) - 33'(held_pos_ff[i2]));
            op_b = signed'(MUL_W'(tp));
         end
         ST_DOT_MUL: begin
            op_a = MUL_W'(held_q_ff[i2]);
            op_b = MUL_W'(smp_q[i2]);
         end
         ST_DSQ_MUL: begin
            op_a = dot_ff[MUL_W-1:0];
            op_b = dot_ff[MUL_W-1:0];
         end
         ST_LERP_MUL: begin
            op_a = MUL_W'(34'(bq_ff[i2]) - 34'(held_q_ff[i2]));
            op_b = signed'(MUL_W'(tr));
         end
         ST_TH_MUL: begin
            op_a = theta_ff[MUL_W-1:0];
            op_b = signed'(MUL_W'(tr));
         end
         ST_COMB_MUL: begin
            op_a = idx_ff[0] ? MUL_W'(w_ff[1]) : MUL_W'(w_ff[0]);
            op_b = idx_ff[0] ? MUL_W'(bq_ff[idx_ff[2:1]]) : MUL_W'(held_q_ff[idx_ff[2:1]]);
         end
         ST_SQ_MUL: begin
            op_a = signed'(MUL_W'(mag[i2][32:2]));
            op_b = signed'(MUL_W'(mag[i2][32:2]));
         end
         ST_ROOT0_GO: begin
            root_start = 1'b1;
            root_n     = Q60_ONE - prod_ff[63:0];
         end
         ST_ROOT1_GO: root_start = 1'b1;
         ST_VEC_GO: begin
            cord_start = 1'b1;
            cord_vec   = 1'b1;
            cord_x0    = dot_ff;
            cord_y0    = signed'(CORD_W'(s0_ff));
            cord_z0    = '0;
         end
         ST_ROT_GO: cord_start = 1'b1;
         ST_WDIV_GO: begin
            div_start = 1'b1;
            div_num   = {sabs[33:0], 30'b0};
            div_den   = s0_ff;
         end
         ST_NDIV_GO: div_start = 1'b1;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         s_pos_ff      <= '0;
         s_rot_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) held_pos_ff[k] <= '0;
         for (int k = 0; k < 4; k++) held_q_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_index == CSR_POS_SMOOTH) s_pos_ff <= csr_val;
         if (csr_valid && csr_index == CSR_ROT_SMOOTH) s_rot_ff <= csr_val;
         if (state_ff == ST_DONE && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE && out_free) begin
            held_valid_ff <= smp_ff.in_valid;
            for (int k = 0; k < 3; k++) held_pos_ff[k] <= pos_res_ff[k];
            for (int k = 0; k < 4; k++) held_q_ff[k] <= qout_ff[k];
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            idx_ff <= '0;
            if (req_valid) begin
               smp_ff        <= req_data;
               pos_res_ff[0] <= req_data.in_pos_x;
               pos_res_ff[1] <= req_data.in_pos_y;
               pos_res_ff[2] <= req_data.in_pos_z;
               qout_ff[0]    <= req_data.in_quat_w;
               qout_ff[1]    <= req_data.in_quat_x;
               qout_ff[2]    <= req_data.in_quat_y;
               qout_ff[3]    <= req_data.in_quat_z;
            end
         end
         ST_POS_ACC: begin
            pos_res_ff[i2] <= held_pos_ff[i2] + prod_r16[31:0];
            idx_ff         <= (idx_ff == 3'd2) ? 3'd0 : idx_ff + 3'd1;
         end
         ST_DOT_ACC: begin
            dot_ff <= (idx_ff == 3'd0) ? prod_f30[35:0] : dot_ff + prod_f30[35:0];
            idx_ff <= (idx_ff == 3'd3) ? 3'd0 : idx_ff + 3'd1;
         end
         ST_DOT_FIX: begin
            dot_ff <= dabs;
            for (int k = 0; k < 4; k++)
               bq_ff[k] <= (dot_ff < 0) ? -33'(smp_q[k]) : 33'(smp_q[k]);
         end
         ST_LERP_ACC: begin
            c_ff[i2] <= clamp_c(lerp_sum);
            idx_ff   <= (idx_ff == 3'd3) ? 3'd0 : idx_ff + 3'd1;
         end
         ST_ROOT0_WAIT: if (root_done) s0_ff <= root_res[31:0];
         ST_VEC_WAIT:   if (cord_done) theta_ff <= cord_z;
         ST_TH_ACC: begin
            ub_ff <= prod_r16[35:0];
            ua_ff <= theta_ff - prod_r16[35:0];
         end
         ST_ROT_WAIT: begin
            if (cord_done) begin
               sin_ff[idx_ff[0]] <= cord_y;
               idx_ff            <= idx_ff[0] ? 3'd0 : 3'd1;
            end
         end
         ST_WDIV_WAIT: begin
            if (div_done) begin
               w_ff[idx_ff[0]] <= (sin_ff[idx_ff[0]] < 0) ? -wq : wq;
               idx_ff          <= idx_ff[0] ? 3'd0 : 3'd1;
            end
         end
         ST_COMB_ACC: begin
            if (!idx_ff[0])
               comb_ff <= prod_ff[64:0];
            else
               c_ff[idx_ff[2:1]] <= clamp_c(comb_sum);
            idx_ff <= idx_ff + 3'd1;
         end
         ST_SQ_ACC: begin
            sum_ff <= (idx_ff == 3'd0) ? prod_ff[63:0] : sum_ff + prod_ff[63:0];
            idx_ff <= (idx_ff == 3'd3) ? 3'd0 : idx_ff + 3'd1;
         end
         ST_ROOT1_WAIT: begin
            if (root_done) begin
               len_ff <= root_res[31:0];
               if (root_res == '0)
                  for (int k = 0; k < 4; k++) qout_ff[k] <= '0;
            end
         end
         ST_NDIV_WAIT: begin
            if (div_done) begin
               qout_ff[i2] <= nq;
               idx_ff      <= idx_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_ff.out_pos_x  <= pos_res_ff[0];
               rsp_ff.out_pos_y  <= pos_res_ff[1];
               rsp_ff.out_pos_z  <= pos_res_ff[2];
               rsp_ff.out_quat_w <= qout_ff[0];
               rsp_ff.out_quat_x <= qout_ff[1];
               rsp_ff.out_quat_y <= qout_ff[2];
               rsp_ff.out_quat_z <= qout_ff[3];
               rsp_ff.out_valid  <= smp_ff.in_valid;
               rsp_ff.out_stamp  <= smp_ff.in_stamp;
            end
         end
         default: ;
      endcase
   end

endmodule

@@ hdl/hps_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on hps_pkg.
module hps_mul (
   input  logic                               clock,
   input  logic signed [hps_pkg::MUL_W-1:0]   op_a,
   input  logic signed [hps_pkg::MUL_W-1:0]   op_b,
   output logic signed [hps_pkg::PROD_W-1:0]  prod_ff
);
   import hps_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ hdl/hps_cordic.sv @@
// Iterative CORDIC, one micro-rotation a cycle, vectoring or rotation mode.
// Depends on hps_pkg for widths and the arctangent table.
module hps_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               vectoring,
   input  logic signed [hps_pkg::CORD_W-1:0]  x0,
   input  logic signed [hps_pkg::CORD_W-1:0]  y0,
   input  logic signed [hps_pkg::CORD_W-1:0]  z0,
   output logic signed [hps_pkg::CORD_W-1:0]  x_ff,
   output logic signed [hps_pkg::CORD_W-1:0]  y_ff,
   output logic signed [hps_pkg::CORD_W-1:0]  z_ff,
   output logic                               done_ff
);
   import hps_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_in;
   logic                     vec_ff, vec_in;
   logic [4:0]               step_ff, step_in;
   logic signed [CORD_W-1:0] x_in, y_in, z_in;
   logic signed [CORD_W-1:0] dx, dy, ang;
   logic                     dir;

   assign dx  = y_ff >>> step_ff;
   assign dy  = x_ff >>> step_ff;
   assign ang = atan_q30(step_ff);
   assign dir = vec_ff ? (y_ff >= 0) : (z_ff < 0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         vec_in  = vectoring;
         step_in = '0;
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
      end else if (busy_ff) begin
         x_in    = dir ? x_ff + dx : x_ff - dx;
         y_in    = dir ? y_ff - dy : y_ff + dy;
         z_in    = dir ? z_ff + ang : z_ff - ang;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      vec_ff  <= vec_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

endmodule

@@ hdl/hps_root.sv @@
// Bit-pair integer square root of a 64-bit value, one step a cycle.
// Depends on hps_pkg for the step count.
module hps_root (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [63:0] res_ff,
   output logic        done_ff
);
   import hps_pkg::*;

   logic        busy_ff, busy_in, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in, bit_ff, bit_in, res_in;
   logic [64:0] trial;
   logic        ge;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign ge    = {1'b0, n_ff} >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      bit_in  = bit_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = radicand;
         bit_in  = 64'h4000_0000_0000_0000;
         res_in  = '0;
      end else if (busy_ff) begin
         n_in   = ge ? n_ff - trial[63:0] : n_ff;
         res_in = ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      bit_ff <= bit_in;
      res_ff <= res_in;
   end

endmodule

@@ hdl/hps_div.sv @@
// Shift-subtract divider giving a 31-bit quotient and an overflow flag.
// Depends on hps_pkg for the step count.
module hps_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic [30:0] quot_ff,
   output logic        sat_ff,
   output logic        done_ff
);
   import hps_pkg::*;

   logic        busy_ff, busy_in, done_in, sat_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [62:0] dsh_ff, dsh_in;
   logic [30:0] quot_in;
   logic [62:0] dsh0;
   logic        ge;

   assign dsh0 = {den, 31'b0};
   assign ge   = rem_ff >= {1'b0, dsh_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = num;
         dsh_in  = dsh0;
         quot_in = '0;
         sat_in  = num >= {1'b0, dsh0};
      end else if (busy_ff) begin
         dsh_in  = dsh_ff >> 1;
         rem_in  = ge ? rem_ff - {1'b0, dsh_ff} : rem_ff;
         quot_in = {quot_ff[29:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // first step compares against den << 30
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsh_ff  <= start ? dsh0 >> 1 : dsh_in;
      quot_ff <= quot_in;
      sat_ff  <= sat_in;
   end

endmodule
